/* design/dcg_pkg.sv */
// Shared types, widths and constants of the dot chase generator.
`default_nettype none
package dcg_pkg;

  localparam int unsigned DEF_NUM_PIXELS = 60;
  localparam int unsigned PIX_W  = 6;
  localparam int unsigned COL_W  = 8;
  localparam int unsigned LVL_W  = 8;
  localparam int unsigned SPC_W  = 7;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned SKIP_W = 5;
  localparam int unsigned XPIX_W = 3;

  localparam logic [LVL_W-1:0]  SPEED_NOMINAL  = 8'd90;
  localparam logic [LVL_W-1:0]  SPEED_FAST_BASE = 8'd91;
  localparam logic [SKIP_W-1:0] TICK_SKIP_CAP  = 5'd25;
  localparam int unsigned       DOT_MUL  = 19;
  // x/89 as (x*2946)>>18 for x < 5243, folded with the *25
  localparam int unsigned       TICK_MUL = 73650;
  localparam int unsigned       TICK_SH  = 18;
  localparam int unsigned       TICK_PW  = 23;
  // x/163 as (x*1609)>>18 for x < 2131, folded with the *5
  localparam int unsigned       XPIX_MUL = 8045;
  localparam int unsigned       XPIX_SH  = 18;
  localparam int unsigned       XPIX_PW  = 21;
  localparam int unsigned       CNTP_W   = 13;
  localparam int unsigned       WIDP_W   = 14;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_DECIDE,
    ST_DIV,
    ST_POS,
    ST_WIDTH,
    ST_EMIT
  } dcg_state_t;

  typedef struct packed {
    logic [COL_W-1:0] dot_red;
    logic [COL_W-1:0] dot_green;
    logic [COL_W-1:0] dot_blue;
    logic [COL_W-1:0] back_red;
    logic [COL_W-1:0] back_green;
    logic [COL_W-1:0] back_blue;
  } dcg_colors_t;

  typedef struct packed {
    logic [PIX_W-1:0] chase;
    logic [SPC_W-1:0] spacing;
    logic [SPC_W-1:0] width;
    logic [CNT_W-1:0] dots;
  } dcg_scan_cfg_t;

  typedef struct packed {
    logic             start;
    logic [SPC_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } dcg_div_req_t;

  typedef struct packed {
    logic             done;
    logic [SPC_W-1:0] quotient;
  } dcg_div_rsp_t;

  // floor(x/255) for x below 65280
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = 17'(x) + 17'(x[15:8]) + 17'd1;
    return s[15:8];
  endfunction

endpackage
`default_nettype wire

/* design/dcg_ifs.sv */
// Valid/ready channel interfaces for lighting parameters and pixel results.
`default_nettype none
interface dcg_in_if;
  import dcg_pkg::*;
  logic             valid;
  logic             ready;
  logic [COL_W-1:0] dot_red;
  logic [COL_W-1:0] dot_green;
  logic [COL_W-1:0] dot_blue;
  logic [LVL_W-1:0] speed_level;
  logic [LVL_W-1:0] count_level;
  logic [LVL_W-1:0] width_level;
  logic [COL_W-1:0] back_red;
  logic [COL_W-1:0] back_green;
  logic [COL_W-1:0] back_blue;

  modport source (output valid, dot_red, dot_green, dot_blue, speed_level, count_level,
                  width_level, back_red, back_green, back_blue, input ready);
  modport sink (input valid, dot_red, dot_green, dot_blue, speed_level, count_level,
                width_level, back_red, back_green, back_blue, output ready);
endinterface

interface dcg_out_if;
  import dcg_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_index;
  logic [COL_W-1:0] pixel_red;
  logic [COL_W-1:0] pixel_green;
  logic [COL_W-1:0] pixel_blue;
  logic             frame_end;

  modport source (output valid, pixel_index, pixel_red, pixel_green, pixel_blue, frame_end,
                  input ready);
  modport sink (input valid, pixel_index, pixel_red, pixel_green, pixel_blue, frame_end,
                output ready);
endinterface
`default_nettype wire

/* design/dcg_div.sv */
// Restoring divider, one quotient bit per cycle, for the dot spacing.
`default_nettype none
module dcg_div (
  input  wire                   clk,
  input  wire                   rst_n,
  input  dcg_pkg::dcg_div_req_t req,
  output dcg_pkg::dcg_div_rsp_t rsp
);
  import dcg_pkg::*;

  localparam int unsigned StepW = $clog2(SPC_W);

  logic             busy_r;
  logic             done_r;
  logic [StepW-1:0] step_r;
  logic [SPC_W-1:0] dvd_r;
  logic [CNT_W-1:0] rem_r;
  logic [CNT_W-1:0] den_r;

  logic [CNT_W:0]   rem_sh;
  logic             fits;
  logic [CNT_W:0]   rem_diff;

  assign rem_sh   = {rem_r, dvd_r[SPC_W-1]};
  assign fits     = rem_sh >= {1'b0, den_r};
  assign rem_diff = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == StepW'(SPC_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      rem_r <= '0;
      den_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= fits ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      dvd_r <= {dvd_r[SPC_W-2:0], fits};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = dvd_r;

endmodule
`default_nettype wire

/* design/dcg_scan.sv */
// Pixel scanner: walks the strip one pixel per transfer and paints dot or background.
`default_nettype none
module dcg_scan #(
  parameter int unsigned NumPixels = dcg_pkg::DEF_NUM_PIXELS
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    start,
  input  dcg_pkg::dcg_scan_cfg_t cfg,
  input  dcg_pkg::dcg_colors_t   colors,
  output logic                   done,
  dcg_out_if.source              out_chan
);
  import dcg_pkg::*;

  dcg_scan_cfg_t    cfg_r;
  dcg_colors_t      col_r;
  logic             active_r;
  logic             done_r;
  logic [PIX_W-1:0] pix_r;
  logic             started_r;
  logic [SPC_W-1:0] ph_r;
  logic [SPC_W-1:0] q_r;

  logic             out_valid_r;
  logic [PIX_W-1:0] out_idx_r;
  logic [COL_W-1:0] out_red_r;
  logic [COL_W-1:0] out_green_r;
  logic [COL_W-1:0] out_blue_r;
  logic             out_end_r;

  logic             hit;
  logic             cur_on;
  logic [SPC_W-1:0] cur_ph;
  logic [SPC_W-1:0] cur_q;
  logic             lit;
  logic             wrap;
  logic             last;
  logic             load;

  assign hit    = pix_r == cfg_r.chase;
  assign cur_on = started_r | hit;
  assign cur_ph = hit ? '0 : ph_r;
  assign cur_q  = hit ? '0 : q_r;
  assign lit    = cur_on && (cur_ph < cfg_r.width) && (cur_q < SPC_W'(cfg_r.dots));
  assign wrap   = (cur_ph + 1'b1) == cfg_r.spacing;
  assign last   = pix_r == PIX_W'(NumPixels - 1);
  assign load   = active_r && !start && (!out_valid_r || out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (start) begin
        active_r <= 1'b1;
      end else if (load) begin
        if (last) begin
          active_r <= 1'b0;
          done_r   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cfg_r     <= cfg;
      col_r     <= colors;
      pix_r     <= '0;
      started_r <= 1'b0;
      ph_r      <= '0;
      q_r       <= '0;
    end else if (load) begin
      pix_r       <= pix_r + 1'b1;
      started_r   <= cur_on;
      ph_r        <= wrap ? '0 : cur_ph + 1'b1;
      q_r         <= cur_q + SPC_W'(wrap);
      out_idx_r   <= pix_r;
      out_red_r   <= lit ? col_r.dot_red   : col_r.back_red;
      out_green_r <= lit ? col_r.dot_green : col_r.back_green;
      out_blue_r  <= lit ? col_r.dot_blue  : col_r.back_blue;
      out_end_r   <= last;
    end
  end

  assign done                 = done_r;
  assign out_chan.valid       = out_valid_r;
  assign out_chan.pixel_index = out_idx_r;
  assign out_chan.pixel_red   = out_red_r;
  assign out_chan.pixel_green = out_green_r;
  assign out_chan.pixel_blue  = out_blue_r;
  assign out_chan.frame_end   = out_end_r;

`ifndef SYNTHESIS
  a_phase_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r && started_r) |-> (ph_r < cfg_r.spacing))
    else $error("dot phase ran past the spacing");

  a_frame_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_end_r) |-> (out_idx_r == PIX_W'(NumPixels - 1)))
    else $error("frame end flagged on a pixel other than the last");
`endif

endmodule
`default_nettype wire

/* design/led_strip_dot_chase_generator.sv */
// Top level of the dot chase generator: sequencer, speed and size arithmetic.
//
// Usage: in_chan carries one frame tick of nine lighting bytes (dot color,
// speed, count, width, background color); out_chan returns pixels.
// A tick is taken when in_chan.ready is high, which is only while the
// sequencer is idle; one tick is handled at a time.
// A skipped tick (slow speed) produces no pixels and frees the input once
// the sequencer has passed CALC and DECIDE. A move produces NumPixels
// transfers, pixel 0 first, frame_end on the last. The first pixel follows
// the tick transfer through CALC, DECIDE, DIV, POS and WIDTH (scaling
// multiplies plus a bit-serial divide for the spacing), then one pixel per
// cycle while out_chan.ready holds. The last pixel may still sit in the
// output register when the next tick is already taken.
// A stalled receiver freezes the pixel walk; nothing is dropped.
// Reset (rst_n low, synchronous) clears the skip counter, the chase position
// and all valid flags.
`default_nettype none
module led_strip_dot_chase_generator #(
  parameter int unsigned NumPixels = dcg_pkg::DEF_NUM_PIXELS
) (
  input  wire       clk,
  input  wire       rst_n,
  dcg_in_if.sink    in_chan,
  dcg_out_if.source out_chan
);
  import dcg_pkg::*;

  dcg_state_t        state_r;
  dcg_state_t        state_nxt;

  dcg_colors_t       colors_r;
  logic [LVL_W-1:0]  speed_r;
  logic [LVL_W-1:0]  cnt_lvl_r;
  logic [LVL_W-1:0]  wid_lvl_r;
  logic [TICK_PW-1:0] tick_prod_r;
  logic [XPIX_PW-1:0] xpix_prod_r;
  logic [CNTP_W-1:0] cnt_prod_r;
  logic [SKIP_W-1:0] skip_cnt_r;
  logic [PIX_W-1:0]  chase_r;
  logic [XPIX_W-1:0] xpix_r;
  logic [CNT_W-1:0]  dots_r;
  logic [SPC_W-1:0]  spacing_r;
  logic [WIDP_W-1:0] wid_prod_r;

  logic              in_ready;
  logic              move;
  logic [SKIP_W-1:0] skip_ticks;
  logic [XPIX_W-1:0] xpix;
  logic [CNT_W-1:0]  dots;
  logic [SPC_W-1:0]  pos;
  logic [7:0]        wid_q;
  logic [LVL_W-1:0]  fast_diff;

  dcg_div_req_t      div_req;
  dcg_div_rsp_t      div_rsp;
  dcg_scan_cfg_t     scan_cfg;
  logic              scan_start;
  logic              scan_done;

  assign skip_ticks = (speed_r < SPEED_NOMINAL) ?
                      TICK_SKIP_CAP - tick_prod_r[TICK_SH +: SKIP_W] : '0;
  assign xpix       = (speed_r > SPEED_NOMINAL) ? xpix_prod_r[XPIX_SH +: XPIX_W] : '0;
  assign dots       = CNT_W'(div255(16'(cnt_prod_r))) + 1'b1;
  assign move       = !(skip_cnt_r < skip_ticks);
  assign pos        = SPC_W'(chase_r) + SPC_W'(xpix_r) + 1'b1;
  assign wid_q      = div255(16'(wid_prod_r));
  assign fast_diff  = speed_r - SPEED_FAST_BASE;

  assign div_req.start    = (state_r == ST_DECIDE) && move;
  assign div_req.dividend = SPC_W'(NumPixels);
  assign div_req.divisor  = dots;

  assign scan_cfg.chase   = chase_r;
  assign scan_cfg.spacing = spacing_r;
  assign scan_cfg.width   = SPC_W'(wid_q) + 1'b1;
  assign scan_cfg.dots    = dots_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    scan_start = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_chan.valid) begin
          state_nxt = ST_CALC;
        end
      end
      ST_CALC:   state_nxt = ST_DECIDE;
      ST_DECIDE: state_nxt = move ? ST_DIV : ST_IDLE;
      ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = ST_POS;
        end
      end
      ST_POS:    state_nxt = ST_WIDTH;
      ST_WIDTH: begin
        scan_start = 1'b1;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        if (scan_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_cnt_r <= '0;
      chase_r    <= '0;
    end else begin
      if (state_r == ST_DECIDE) begin
        skip_cnt_r <= move ? '0 : skip_cnt_r + 1'b1;
      end
      if (state_r == ST_POS) begin
        chase_r <= (pos >= spacing_r) ? '0 : pos[PIX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_chan.valid) begin
      colors_r.dot_red    <= in_chan.dot_red;
      colors_r.dot_green  <= in_chan.dot_green;
      colors_r.dot_blue   <= in_chan.dot_blue;
      colors_r.back_red   <= in_chan.back_red;
      colors_r.back_green <= in_chan.back_green;
      colors_r.back_blue  <= in_chan.back_blue;
      speed_r             <= in_chan.speed_level;
      cnt_lvl_r           <= in_chan.count_level;
      wid_lvl_r           <= in_chan.width_level;
    end
    if (state_r == ST_CALC) begin
      tick_prod_r <= TICK_PW'(speed_r) * TICK_PW'(TICK_MUL);
      xpix_prod_r <= XPIX_PW'(fast_diff) * XPIX_PW'(XPIX_MUL);
      cnt_prod_r  <= CNTP_W'(cnt_lvl_r) * CNTP_W'(DOT_MUL);
    end
    if (state_r == ST_DECIDE) begin
      xpix_r <= xpix;
      dots_r <= dots;
    end
    if (state_r == ST_DIV && div_rsp.done) begin
      spacing_r <= div_rsp.quotient;
    end
    if (state_r == ST_POS) begin
      wid_prod_r <= WIDP_W'(wid_lvl_r) * WIDP_W'(spacing_r - 1'b1);
    end
  end

  assign in_chan.ready = in_ready;

  dcg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  dcg_scan #(
    .NumPixels (NumPixels)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (scan_start),
    .cfg      (scan_cfg),
    .colors   (colors_r),
    .done     (scan_done),
    .out_chan (out_chan)
  );

`ifndef SYNTHESIS
  a_skip_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    skip_cnt_r <= TICK_SKIP_CAP)
    else $error("skip counter above its limit");

  a_chase_in_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WIDTH) |-> (SPC_W'(chase_r) < spacing_r))
    else $error("chase position not below the spacing");

  a_spacing_quotient: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && div_rsp.done) |->
      ((12'(div_rsp.quotient) * 12'(dots_r) <= 12'(NumPixels)) &&
       (12'(div_rsp.quotient) * 12'(dots_r) + 12'(dots_r) > 12'(NumPixels))))
    else $error("spacing quotient wrong");
`endif

endmodule
`default_nettype wire
